// ===== src/prp_pkg.sv =====
// Shared constants and the arctangent table for the planar relative pose core.
package prp_pkg;

    localparam int POS_WIDTH_DEF       = 32;
    localparam int ANGLE_WIDTH_DEF     = 16;
    localparam int ROTATION_STAGES_DEF = 16;

    // Extra fraction bits carried through the rotation.
    localparam int GUARD_BITS = 8;

    // Inverse rotation gain in Q0.32.
    localparam int KINV_WIDTH = 32;
    localparam logic [KINV_WIDTH-1:0] KINV = 32'd2608131497;

    // Rotation residual angle, scaled to 2^32 per turn.
    localparam int RES_WIDTH = 32;

    localparam int ATAN_ENTRIES = 24;

    // Arctangent of 2^-idx, in units of 2^32 per turn.
    function automatic logic [31:0] atan_turn32(input int idx);
        logic [31:0] val;
        case (idx)
            0:       val = 32'd536870912;
            1:       val = 32'd316933406;
            2:       val = 32'd167458907;
            3:       val = 32'd85004756;
            4:       val = 32'd42667331;
            5:       val = 32'd21354465;
            6:       val = 32'd10679838;
            7:       val = 32'd5340245;
            8:       val = 32'd2670163;
            9:       val = 32'd1335087;
            10:      val = 32'd667544;
            11:      val = 32'd333772;
            12:      val = 32'd166886;
            13:      val = 32'd83443;
            14:      val = 32'd41722;
            15:      val = 32'd20861;
            16:      val = 32'd10430;
            17:      val = 32'd5215;
            18:      val = 32'd2608;
            19:      val = 32'd1304;
            20:      val = 32'd652;
            21:      val = 32'd326;
            22:      val = 32'd163;
            23:      val = 32'd81;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== src/prp_front.sv =====
// Front end: position difference, quadrant pre-rotation and gain compensation.
module prp_front #(
    parameter int POS_WIDTH   = prp_pkg::POS_WIDTH_DEF,
    parameter int ANGLE_WIDTH = prp_pkg::ANGLE_WIDTH_DEF,
    parameter int XW          = POS_WIDTH + prp_pkg::GUARD_BITS + 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [POS_WIDTH-1:0]   target_x,
    input  logic signed [POS_WIDTH-1:0]   target_y,
    input  logic        [ANGLE_WIDTH-1:0] target_heading,
    input  logic signed [POS_WIDTH-1:0]   ref_x,
    input  logic signed [POS_WIDTH-1:0]   ref_y,
    input  logic        [ANGLE_WIDTH-1:0] ref_heading,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [XW-1:0]          x_out,
    output logic signed [XW-1:0]          y_out,
    output logic signed [prp_pkg::RES_WIDTH-1:0] r_out,
    output logic                          ovf_out,
    output logic        [ANGLE_WIDTH-1:0] hd_out
);

    localparam int P    = POS_WIDTH;
    localparam int A    = ANGLE_WIDTH;
    localparam int G    = prp_pkg::GUARD_BITS;
    localparam int KW   = prp_pkg::KINV_WIDTH;
    localparam int RW   = prp_pkg::RES_WIDTH;
    localparam int LO_W = P / 2;
    localparam int HI_W = P - LO_W;
    localparam int SUMW = P + KW;
    localparam int MW   = P + G;
    localparam int SW   = 1 + A + RW;
    localparam int NSTG = 5;

    localparam logic [P-1:0]    POS_MAX   = {1'b0, {(P-1){1'b1}}};
    localparam logic [P-1:0]    POS_MIN   = {1'b1, {(P-1){1'b0}}};
    localparam logic [A-1:0]    EIGHTH    = A'(1) << (A - 3);
    localparam logic [SUMW-1:0] ROUND_MUL = SUMW'(1) << (KW - 1 - G);

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] load;
    logic [SW-1:0]   side_reg [NSTG];
    logic [SW-1:0]   side_next;

    // Stage 1 registers.
    logic [P-1:0]    dx_reg, dy_reg, dx_next, dy_next;
    logic [1:0]      q_reg, q_next;
    // Stage 2 registers.
    logic [P-1:0]    mag_a_reg, mag_b_reg, mag_a_next, mag_b_next;
    logic [1:0]      neg2_reg, neg2_next;
    // Stage 3 registers.
    logic [LO_W+KW-1:0] pla_reg, plb_reg, pla_next, plb_next;
    logic [HI_W+KW-1:0] pha_reg, phb_reg, pha_next, phb_next;
    logic [1:0]      neg3_reg;
    // Stage 4 registers.
    logic [MW-1:0]   ma_reg, mb_reg, ma_next, mb_next;
    logic [1:0]      neg4_reg;
    // Stage 5 registers.
    logic signed [XW-1:0] x5_reg, y5_reg, x5_next, y5_next;

    // A stage loads when it is empty or when the stage after it loads.
    always_comb
    begin
        load[NSTG-1] = !valid_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    assign in_ready = load[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (load[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Stage 1: saturated differences, heading difference, quadrant and residual.
    always_comb
    begin
        logic [P:0]   dx_full, dy_full;
        logic         sat_x, sat_y;
        logic [A-1:0] hd, z, zq, zr;
        dx_full = {target_x[P-1], target_x} - {ref_x[P-1], ref_x};
        dy_full = {target_y[P-1], target_y} - {ref_y[P-1], ref_y};
        sat_x   = dx_full[P] != dx_full[P-1];
        sat_y   = dy_full[P] != dy_full[P-1];
        dx_next = sat_x ? (dx_full[P] ? POS_MIN : POS_MAX) : dx_full[P-1:0];
        dy_next = sat_y ? (dy_full[P] ? POS_MIN : POS_MAX) : dy_full[P-1:0];
        hd      = target_heading - ref_heading;
        z       = A'(0) - ref_heading;
        zq      = z + EIGHTH;
        q_next  = zq[A-1:A-2];
        zr      = z - {q_next, {(A-2){1'b0}}};
        side_next = {sat_x || sat_y, hd, zr, {(RW-A){1'b0}}};
    end

    // Stage 2: quadrant swap and sign-magnitude split.
    always_comb
    begin
        logic [P-1:0] src_a, src_b;
        logic         flip_a, flip_b;
        src_a  = q_reg[0] ? dy_reg : dx_reg;
        src_b  = q_reg[0] ? dx_reg : dy_reg;
        flip_a = q_reg[0] ^ q_reg[1];
        flip_b = q_reg[1];
        mag_a_next   = src_a[P-1] ? (~src_a + 1'b1) : src_a;
        mag_b_next   = src_b[P-1] ? (~src_b + 1'b1) : src_b;
        neg2_next[0] = src_a[P-1] ^ flip_a;
        neg2_next[1] = src_b[P-1] ^ flip_b;
    end

    // Stage 3: partial products with the inverse gain.
    always_comb
    begin
        pla_next = (LO_W+KW)'(mag_a_reg[LO_W-1:0]) * (LO_W+KW)'(prp_pkg::KINV);
        plb_next = (LO_W+KW)'(mag_b_reg[LO_W-1:0]) * (LO_W+KW)'(prp_pkg::KINV);
        pha_next = (HI_W+KW)'(mag_a_reg[P-1:LO_W]) * (HI_W+KW)'(prp_pkg::KINV);
        phb_next = (HI_W+KW)'(mag_b_reg[P-1:LO_W]) * (HI_W+KW)'(prp_pkg::KINV);
    end

    // Stage 4: sum the partial products and round to the guard-bit scale.
    always_comb
    begin
        logic [SUMW-1:0] sum_a, sum_b;
        sum_a   = (SUMW'(pha_reg) << LO_W) + SUMW'(pla_reg) + ROUND_MUL;
        sum_b   = (SUMW'(phb_reg) << LO_W) + SUMW'(plb_reg) + ROUND_MUL;
        ma_next = sum_a[SUMW-1:KW-G];
        mb_next = sum_b[SUMW-1:KW-G];
    end

    // Stage 5: apply the combined sign.
    always_comb
    begin
        logic signed [XW-1:0] ext_a, ext_b;
        ext_a   = $signed(XW'(ma_reg));
        ext_b   = $signed(XW'(mb_reg));
        x5_next = neg4_reg[0] ? -ext_a : ext_a;
        y5_next = neg4_reg[1] ? -ext_b : ext_b;
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            q_reg       <= q_next;
            side_reg[0] <= side_next;
        end
        if (load[1])
        begin
            mag_a_reg   <= mag_a_next;
            mag_b_reg   <= mag_b_next;
            neg2_reg    <= neg2_next;
            side_reg[1] <= side_reg[0];
        end
        if (load[2])
        begin
            pla_reg     <= pla_next;
            plb_reg     <= plb_next;
            pha_reg     <= pha_next;
            phb_reg     <= phb_next;
            neg3_reg    <= neg2_reg;
            side_reg[2] <= side_reg[1];
        end
        if (load[3])
        begin
            ma_reg      <= ma_next;
            mb_reg      <= mb_next;
            neg4_reg    <= neg3_reg;
            side_reg[3] <= side_reg[2];
        end
        if (load[4])
        begin
            x5_reg      <= x5_next;
            y5_reg      <= y5_next;
            side_reg[4] <= side_reg[3];
        end
    end

    assign out_valid = valid_reg[NSTG-1];
    assign x_out     = x5_reg;
    assign y_out     = y5_reg;
    assign ovf_out   = side_reg[NSTG-1][SW-1];
    assign hd_out    = side_reg[NSTG-1][SW-2:RW];
    assign r_out     = $signed(side_reg[NSTG-1][RW-1:0]);

endmodule

// ===== src/prp_cordic_cell.sv =====
// One CORDIC micro-rotation cell with its own pipeline register and handshake.
module prp_cordic_cell #(
    parameter int XW          = prp_pkg::POS_WIDTH_DEF + prp_pkg::GUARD_BITS + 2,
    parameter int ANGLE_WIDTH = prp_pkg::ANGLE_WIDTH_DEF,
    parameter int STAGE       = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [XW-1:0]          x_in,
    input  logic signed [XW-1:0]          y_in,
    input  logic signed [prp_pkg::RES_WIDTH-1:0] r_in,
    input  logic                          ovf_in,
    input  logic        [ANGLE_WIDTH-1:0] hd_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [XW-1:0]          x_out,
    output logic signed [XW-1:0]          y_out,
    output logic signed [prp_pkg::RES_WIDTH-1:0] r_out,
    output logic                          ovf_out,
    output logic        [ANGLE_WIDTH-1:0] hd_out
);

    localparam int RW = prp_pkg::RES_WIDTH;
    localparam logic signed [RW-1:0] ATAN = $signed(prp_pkg::atan_turn32(STAGE));

    logic                   valid_reg;
    logic                   load;
    logic signed [XW-1:0]   x_reg, y_reg, x_next, y_next;
    logic signed [RW-1:0]   r_reg, r_next;
    logic                   ovf_reg;
    logic [ANGLE_WIDTH-1:0] hd_reg;

    assign load     = !valid_reg || out_ready;
    assign in_ready = load;

    // Rotate toward a zero residual.
    always_comb
    begin
        logic signed [XW-1:0] xs, ys;
        xs = x_in >>> STAGE;
        ys = y_in >>> STAGE;
        if (!r_in[RW-1])
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            r_next = r_in - ATAN;
        end
        else
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            r_next = r_in + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            r_reg   <= r_next;
            ovf_reg <= ovf_in;
            hd_reg  <= hd_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign r_out     = r_reg;
    assign ovf_out   = ovf_reg;
    assign hd_out    = hd_reg;

endmodule

// ===== src/prp_back.sv =====
// Output stage: removes the guard bits with rounding, saturates and holds the result.
module prp_back #(
    parameter int POS_WIDTH   = prp_pkg::POS_WIDTH_DEF,
    parameter int ANGLE_WIDTH = prp_pkg::ANGLE_WIDTH_DEF,
    parameter int XW          = POS_WIDTH + prp_pkg::GUARD_BITS + 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [XW-1:0]          x_in,
    input  logic signed [XW-1:0]          y_in,
    input  logic                          ovf_in,
    input  logic        [ANGLE_WIDTH-1:0] hd_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [POS_WIDTH-1:0]   rel_x,
    output logic signed [POS_WIDTH-1:0]   rel_y,
    output logic signed [ANGLE_WIDTH-1:0] rel_heading,
    output logic                          overflow
);

    localparam int P  = POS_WIDTH;
    localparam int G  = prp_pkg::GUARD_BITS;
    localparam int TW = XW - G;

    localparam logic signed [XW-1:0] HALF = $signed(XW'(1) << (G - 1));
    localparam logic [P-1:0] POS_MAX = {1'b0, {(P-1){1'b1}}};
    localparam logic [P-1:0] POS_MIN = {1'b1, {(P-1){1'b0}}};

    logic                   valid_reg;
    logic                   load;
    logic [P-1:0]           rel_x_reg, rel_y_reg, rel_x_next, rel_y_next;
    logic [ANGLE_WIDTH-1:0] rel_heading_reg;
    logic                   overflow_reg, overflow_next;

    assign load     = !valid_reg || out_ready;
    assign in_ready = load;

    always_comb
    begin
        logic signed [XW-1:0] xa, ya;
        logic [TW-1:0]        xt, yt;
        logic                 sat_x, sat_y;
        xa    = x_in + HALF;
        ya    = y_in + HALF;
        xt    = xa[XW-1:G];
        yt    = ya[XW-1:G];
        // In range when every bit above the sign of the result agrees with it.
        sat_x = !((&xt[TW-1:P-1]) || !(|xt[TW-1:P-1]));
        sat_y = !((&yt[TW-1:P-1]) || !(|yt[TW-1:P-1]));
        rel_x_next    = sat_x ? (xt[TW-1] ? POS_MIN : POS_MAX) : xt[P-1:0];
        rel_y_next    = sat_y ? (yt[TW-1] ? POS_MIN : POS_MAX) : yt[P-1:0];
        overflow_next = ovf_in || sat_x || sat_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rel_x_reg       <= rel_x_next;
            rel_y_reg       <= rel_y_next;
            rel_heading_reg <= hd_in;
            overflow_reg    <= overflow_next;
        end
    end

    assign out_valid   = valid_reg;
    assign rel_x       = $signed(rel_x_reg);
    assign rel_y       = $signed(rel_y_reg);
    assign rel_heading = $signed(rel_heading_reg);
    assign overflow    = overflow_reg;

endmodule

// ===== src/planar_relative_pose_core.sv =====
// Top level of the planar relative pose core: front end, rotation cell chain, output stage.
//
// The core takes a target pose and a reference pose (x, y in signed Q16.16,
// headings as binary angles with one full turn per 2^ANGLE_WIDTH codes) and
// returns the target expressed in the reference frame, plus the wrapped
// heading difference and an overflow flag for saturated positions.
// Requests enter on in_valid/in_ready and results leave on out_valid/out_ready.
// Every request produces exactly one result, in request order.
// An accepted request passes through the five front-end stages, then one cell
// per CORDIC micro-rotation, and then the output register.
// Throughput is one request per clock while the receiver keeps up; the rotation
// is fully unrolled, so each micro-rotation cell and each front-end stage takes
// a new request every cycle.
// Reset clears every valid bit; no result is pending after reset.
// When the receiver stalls, each stage holds its request while the next stage
// is full, and empty stages still fill, so bubbles collapse. in_ready drops only
// once every stage in the chain holds a request.
module planar_relative_pose_core #(
    parameter int POS_WIDTH       = prp_pkg::POS_WIDTH_DEF,
    parameter int ANGLE_WIDTH     = prp_pkg::ANGLE_WIDTH_DEF,
    parameter int ROTATION_STAGES = prp_pkg::ROTATION_STAGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [POS_WIDTH-1:0]   target_x,
    input  logic signed [POS_WIDTH-1:0]   target_y,
    input  logic        [ANGLE_WIDTH-1:0] target_heading,
    input  logic signed [POS_WIDTH-1:0]   ref_x,
    input  logic signed [POS_WIDTH-1:0]   ref_y,
    input  logic        [ANGLE_WIDTH-1:0] ref_heading,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [POS_WIDTH-1:0]   rel_x,
    output logic signed [POS_WIDTH-1:0]   rel_y,
    output logic signed [ANGLE_WIDTH-1:0] rel_heading,
    output logic                          overflow
);

    // Rotation datapath width: guard bits plus headroom for the vector growth
    // of a diagonal difference during the micro-rotations.
    localparam int XW = POS_WIDTH + prp_pkg::GUARD_BITS + 2;
    localparam int RW = prp_pkg::RES_WIDTH;
    localparam int N  = ROTATION_STAGES;

    // Chain links; index k feeds cell k, index N feeds the output stage.
    logic                   c_valid [N+1];
    logic                   c_ready [N+1];
    logic signed [XW-1:0]   c_x     [N+1];
    logic signed [XW-1:0]   c_y     [N+1];
    logic signed [RW-1:0]   c_r     [N+1];
    logic                   c_ovf   [N+1];
    logic [ANGLE_WIDTH-1:0] c_hd    [N+1];

    // Difference, quadrant pre-rotation and gain compensation.
    prp_front #(
        .POS_WIDTH   (POS_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .XW          (XW)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .target_x       (target_x),
        .target_y       (target_y),
        .target_heading (target_heading),
        .ref_x          (ref_x),
        .ref_y          (ref_y),
        .ref_heading    (ref_heading),
        .out_valid      (c_valid[0]),
        .out_ready      (c_ready[0]),
        .x_out          (c_x[0]),
        .y_out          (c_y[0]),
        .r_out          (c_r[0]),
        .ovf_out        (c_ovf[0]),
        .hd_out         (c_hd[0])
    );

    // One cell per micro-rotation; each hands its request to the next one.
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        prp_cordic_cell #(
            .XW          (XW),
            .ANGLE_WIDTH (ANGLE_WIDTH),
            .STAGE       (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (c_valid[i]),
            .in_ready  (c_ready[i]),
            .x_in      (c_x[i]),
            .y_in      (c_y[i]),
            .r_in      (c_r[i]),
            .ovf_in    (c_ovf[i]),
            .hd_in     (c_hd[i]),
            .out_valid (c_valid[i+1]),
            .out_ready (c_ready[i+1]),
            .x_out     (c_x[i+1]),
            .y_out     (c_y[i+1]),
            .r_out     (c_r[i+1]),
            .ovf_out   (c_ovf[i+1]),
            .hd_out    (c_hd[i+1])
        );
    end

    // Rounding, saturation and the output register. The final residual is
    // not needed past the last cell.
    prp_back #(
        .POS_WIDTH   (POS_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .XW          (XW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (c_valid[N]),
        .in_ready    (c_ready[N]),
        .x_in        (c_x[N]),
        .y_in        (c_y[N]),
        .ovf_in      (c_ovf[N] || (c_r[N] != c_r[N])),
        .hd_in       (c_hd[N]),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .rel_x       (rel_x),
        .rel_y       (rel_y),
        .rel_heading (rel_heading),
        .overflow    (overflow)
    );

    // With the output register empty, every stage can load, so a request is taken.
    a_empty_out_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input not ready although the output register is empty");

    // A result leaving frees a slot all the way back to the input.
    a_drain_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |-> in_ready)
        else $error("input not ready while a result is being taken");

    // A request in the last cell moves into an empty output register at the
    // next edge.
    a_last_cell_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid[N] && !out_valid) |=> out_valid)
        else $error("request in the last cell did not reach the output register");

endmodule

// ===== bench/planar_relative_pose_checker.sv =====
// Checker for the planar relative pose core: predicts every result and compares it.
`timescale 1ns / 100ps
module planar_relative_pose_checker #(
    parameter int PW = prp_pkg::POS_WIDTH_DEF,
    parameter int AW = prp_pkg::ANGLE_WIDTH_DEF,
    parameter int STAGES = prp_pkg::ROTATION_STAGES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic signed [PW-1:0]   target_x,
    input  logic signed [PW-1:0]   target_y,
    input  logic        [AW-1:0]   target_heading,
    input  logic signed [PW-1:0]   ref_x,
    input  logic signed [PW-1:0]   ref_y,
    input  logic        [AW-1:0]   ref_heading,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic signed [PW-1:0]   rel_x,
    input  logic signed [PW-1:0]   rel_y,
    input  logic signed [AW-1:0]   rel_heading,
    input  logic                   overflow,
    output int                     mismatch_count,
    output int                     pending_count
);

    localparam int PRINT_CAP = 60;

    typedef struct packed {
        logic signed [PW-1:0] rel_x;
        logic signed [PW-1:0] rel_y;
        logic signed [AW-1:0] rel_heading;
        logic                 overflow;
    } pose_result_t;

    // Arctangent of 2^-i, 2^32 per turn.
    localparam longint ARCTAN_TURN [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    pose_result_t pose_expected[$];
    pose_result_t oldest;

    initial mismatch_count = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < PRINT_CAP)
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic longint clamp_pos(input longint v, inout logic hit);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (PW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // Multiply by the inverse CORDIC gain with guard bits, rounding the magnitude.
    function automatic longint scale_by_kinv(input longint v);
        logic        neg;
        logic [95:0] mag;
        logic [95:0] prod;
        neg = (v < 0);
        mag = neg ? 96'(-v) : 96'(v);
        mag = mag << prp_pkg::GUARD_BITS;
        prod = (mag * 96'(prp_pkg::KINV) + 96'h8000_0000) >> 32;
        return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function automatic pose_result_t predict_relative_pose(
        input logic signed [PW-1:0] tx, input logic signed [PW-1:0] ty,
        input logic        [AW-1:0] th, input logic signed [PW-1:0] rx,
        input logic signed [PW-1:0] ry, input logic        [AW-1:0] rh);
        pose_result_t res;
        logic         hit;
        longint       dx, dy, x, y, t, xs, ys;
        longint       amask, z, q, resid, r32;
        int           i;
        hit = 1'b0;
        dx = clamp_pos(longint'(tx) - longint'(rx), hit);
        dy = clamp_pos(longint'(ty) - longint'(ry), hit);
        x = scale_by_kinv(dx);
        y = scale_by_kinv(dy);

        // Rotate by minus the reference heading: exact quarter turns first.
        amask = (longint'(1) <<< AW) - 1;
        z = (-longint'(rh)) & amask;
        q = ((z + (longint'(1) <<< (AW - 3))) >>> (AW - 2)) & 3;
        if (q == 1)
        begin
            t = x; x = -y; y = t;
        end
        else if (q == 2)
        begin
            x = -x; y = -y;
        end
        else if (q == 3)
        begin
            t = x; x = y; y = -t;
        end
        resid = (z - (q <<< (AW - 2))) & amask;
        if (resid[AW-1])
            resid = resid - (longint'(1) <<< AW);
        r32 = resid * (longint'(1) <<< (32 - AW));

        for (i = 0; i < STAGES && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (r32 >= 0)
            begin
                x = x - ys; y = y + xs; r32 = r32 - ARCTAN_TURN[i];
            end
            else
            begin
                x = x + ys; y = y - xs; r32 = r32 + ARCTAN_TURN[i];
            end
        end

        x = clamp_pos((x + (longint'(1) <<< (prp_pkg::GUARD_BITS - 1)))
                      >>> prp_pkg::GUARD_BITS, hit);
        y = clamp_pos((y + (longint'(1) <<< (prp_pkg::GUARD_BITS - 1)))
                      >>> prp_pkg::GUARD_BITS, hit);
        res.rel_x = PW'(x);
        res.rel_y = PW'(y);
        res.rel_heading = AW'(th - rh);
        res.overflow = hit;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_expected.delete();
            pending_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pose_expected.size() == 0)
                begin
                    report_mismatch("result with no request outstanding", longint'(rel_x), 0);
                end
                else
                begin
                    oldest = pose_expected.pop_front();
                    if (rel_x !== oldest.rel_x)
                        report_mismatch("rel_x", longint'(rel_x), longint'(oldest.rel_x));
                    if (rel_y !== oldest.rel_y)
                        report_mismatch("rel_y", longint'(rel_y), longint'(oldest.rel_y));
                    if (rel_heading !== oldest.rel_heading)
                        report_mismatch("rel_heading", longint'(rel_heading),
                                        longint'(oldest.rel_heading));
                    if (overflow !== oldest.overflow)
                        report_mismatch("overflow", longint'(overflow),
                                        longint'(oldest.overflow));
                end
            end
            if (in_valid && in_ready)
                pose_expected.push_back(predict_relative_pose(target_x, target_y,
                    target_heading, ref_x, ref_y, ref_heading));
            pending_count <= pose_expected.size();
        end
    end

endmodule

// ===== bench/tb_planar_relative_pose_core.sv =====
// Testbench top for the planar relative pose core: drives requests and gives the verdict.
`timescale 1ns / 100ps
module tb_planar_relative_pose_core;

    localparam int PW = prp_pkg::POS_WIDTH_DEF;
    localparam int AW = prp_pkg::ANGLE_WIDTH_DEF;

    // Acceptance to out_valid when the receiver keeps up.
    localparam int LATENCY = prp_pkg::ROTATION_STAGES_DEF + 5;

    localparam int RANDOM_REQUESTS = 1680;

    // The long receiver hold-off starts once this many requests went in.
    localparam int HOLD_AFTER  = 400;
    localparam int HOLD_CYCLES = 300;

    // The limit must allow for the slowest legal run: gaps between bursts, a
    // receiver that is ready with a probability of one in five, one long
    // hold-off, and the pipeline latency at the end.
    localparam int CYCLE_LIMIT = 400000;

    localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW - 1){1'b1}}};
    localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW - 1){1'b0}}};
    localparam logic signed [PW-1:0] POS_ONE = PW'(1) << 16;
    localparam logic [AW-1:0] HEAD_EIGHTH  = AW'(1) << (AW - 3);
    localparam logic [AW-1:0] HEAD_QUARTER = AW'(1) << (AW - 2);
    localparam logic [AW-1:0] HEAD_HALF    = AW'(1) << (AW - 1);
    localparam logic [AW-1:0] HEAD_ALL     = {AW{1'b1}};

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [PW-1:0] target_x;
    logic signed [PW-1:0] target_y;
    logic        [AW-1:0] target_heading;
    logic signed [PW-1:0] ref_x;
    logic signed [PW-1:0] ref_y;
    logic        [AW-1:0] ref_heading;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [PW-1:0] rel_x;
    logic signed [PW-1:0] rel_y;
    logic signed [AW-1:0] rel_heading;
    logic                 overflow;

    int mismatch_count;
    int pending_count;
    int sent_count;

    // Set by the receiver while it holds off, so the sender keeps offering
    // requests back to back and the pipeline fills up.
    bit long_hold;

    planar_relative_pose_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .target_x       (target_x),
        .target_y       (target_y),
        .target_heading (target_heading),
        .ref_x          (ref_x),
        .ref_y          (ref_y),
        .ref_heading    (ref_heading),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .rel_x          (rel_x),
        .rel_y          (rel_y),
        .rel_heading    (rel_heading),
        .overflow       (overflow)
    );

    planar_relative_pose_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .target_x       (target_x),
        .target_y       (target_y),
        .target_heading (target_heading),
        .ref_x          (ref_x),
        .ref_y          (ref_y),
        .ref_heading    (ref_heading),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .rel_x          (rel_x),
        .rel_y          (rel_y),
        .rel_heading    (rel_heading),
        .overflow       (overflow),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one request and hold it until the core takes it. The caller is
    // always at a rising edge, so the payload changes only on an edge and
    // stays put while valid is high.
    task automatic offer_pose(
        input logic signed [PW-1:0] tx, input logic signed [PW-1:0] ty,
        input logic        [AW-1:0] th, input logic signed [PW-1:0] rx,
        input logic signed [PW-1:0] ry, input logic        [AW-1:0] rh);
        target_x       <= tx;
        target_y       <= ty;
        target_heading <= th;
        ref_x          <= rx;
        ref_y          <= ry;
        ref_heading    <= rh;
        in_valid       <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sent_count++;
    endtask

    // A coordinate: an extreme, a full-range value, a small value of either
    // sign, or, when near is set, the anchor plus a small offset so that the
    // difference stays in range and the rotation itself gets exercised.
    function automatic logic signed [PW-1:0] pick_coord(
        input logic signed [PW-1:0] anchor, input bit near);
        logic signed [PW-1:0] v;
        v = PW'($urandom);
        if (near)
            return anchor + (v >>> $urandom_range(1, PW - 1));
        case ($urandom_range(0, 5))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       return POS_MAX;
                    1:       return POS_MIN;
                    2:       return '0;
                    3:       return '1;
                    default: return PW'(1);
                endcase
            end
            1, 2:    return v;
            default: return v >>> $urandom_range(4, PW - 1);
        endcase
    endfunction

    // Headings cluster around the octant boundaries, half of which are where the
    // quarter-turn pre-rotation changes, and are otherwise uniform over the turn.
    function automatic logic [AW-1:0] pick_heading();
        if ($urandom_range(0, 3) == 0)
            return AW'(($urandom_range(0, 7) << (AW - 3)) + $urandom_range(0, 2) - 1);
        return AW'($urandom);
    endfunction

    // Receiver: segments of random length, each with its own stall pattern,
    // and one long hold-off once the sender is well under way.
    initial
    begin : receiver
        int mode;
        int seg_len;
        int k;
        int hold_count;
        bit hold_done;
        bit ready_bit;
        out_ready <= 1'b0;
        long_hold = 1'b0;
        hold_done = 1'b0;
        forever
        begin
            if (!hold_done && sent_count >= HOLD_AFTER)
            begin
                long_hold = 1'b1;
                @(posedge clk);
                out_ready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(posedge clk);
                long_hold = 1'b0;
                hold_done = 1'b1;
            end
            else
            begin
                mode = $urandom_range(0, 3);
                seg_len = $urandom_range(8, 64);
                for (k = 0; k < seg_len; k++)
                begin
                    case (mode)
                        0:       ready_bit = 1'b1;
                        1:       ready_bit = $urandom_range(0, 1);
                        2:       ready_bit = ($urandom_range(0, 3) != 0);
                        default: ready_bit = ($urandom_range(0, 4) == 0);
                    endcase
                    @(posedge clk);
                    out_ready <= ready_bit;
                end
            end
        end
    end

    // A run that never finishes fails here.
    initial
    begin : watchdog
        int cycle_count;
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : stimulus
        int burst_len;
        int gap;
        int k;
        logic signed [PW-1:0] rx, ry, tx, ty;
        sent_count = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        target_x = '0;
        target_y = '0;
        target_heading = '0;
        ref_x = '0;
        ref_y = '0;
        ref_heading = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests, back to back.
        offer_pose('0, '0, '0, '0, '0, '0);
        offer_pose(POS_ONE, '0, '0, '0, '0, '0);
        offer_pose(POS_ONE, POS_ONE, '0, '0, '0, HEAD_QUARTER);
        offer_pose(POS_ONE, -POS_ONE, '0, '0, '0, HEAD_HALF);
        offer_pose(-POS_ONE, POS_ONE, '0, '0, '0, HEAD_HALF + HEAD_QUARTER);
        // At two octant boundaries of the quarter-turn choice, and one code off each on the same side.
        offer_pose(POS_ONE * 3, POS_ONE, '0, '0, '0, HEAD_EIGHTH - 1);
        offer_pose(POS_ONE * 3, POS_ONE, '0, '0, '0, HEAD_EIGHTH);
        offer_pose(POS_ONE * 3, POS_ONE, '0, '0, '0, HEAD_ALL - HEAD_EIGHTH + 1);
        offer_pose(POS_ONE * 3, POS_ONE, '0, '0, '0, HEAD_ALL - HEAD_EIGHTH);
        // Position difference saturates high and low.
        offer_pose(POS_MAX, POS_MIN, '0, POS_MIN, POS_MAX, '0);
        offer_pose(POS_MIN, POS_MAX, '0, POS_MAX, POS_MIN, HEAD_QUARTER);
        offer_pose(POS_MAX, '0, '0, -POS_ONE, POS_ONE, 16'd3000);
        // Rotated value leaves the range at forty-five degrees; then the most negative position with no rotation.
        offer_pose(POS_MAX, POS_MAX, '0, '0, '0, HEAD_EIGHTH);
        offer_pose(POS_MAX, POS_MIN, '0, '0, '0, HEAD_ALL - HEAD_EIGHTH + 1);
        offer_pose(POS_MIN, POS_MIN, '0, '0, '0, '0);
        // Heading wrap, with a half turn giving the most negative code.
        offer_pose('0, '0, HEAD_HALF, '0, '0, '0);
        offer_pose('0, '0, '0, '0, '0, HEAD_HALF);
        offer_pose('0, '0, HEAD_ALL, '0, '0, '0);
        offer_pose('0, '0, '0, '0, '0, HEAD_ALL);
        offer_pose('1, '1, HEAD_HALF - 1, '0, '0, HEAD_ALL);
        offer_pose(POS_MAX, '1, HEAD_ALL, '0, '0, HEAD_ALL);

        // Random requests in bursts, with gaps of random length between
        // them and occasional stretches with no gaps at all.
        while (sent_count < RANDOM_REQUESTS + 21)
        begin
            burst_len = $urandom_range(1, 40);
            for (k = 0; k < burst_len; k++)
            begin
                rx = pick_coord('0, 1'b0);
                ry = pick_coord('0, 1'b0);
                if ($urandom_range(0, 3) != 0)
                begin
                    tx = pick_coord(rx, 1'b1);
                    ty = pick_coord(ry, 1'b1);
                end
                else
                begin
                    tx = pick_coord('0, 1'b0);
                    ty = pick_coord('0, 1'b0);
                end
                offer_pose(tx, ty, pick_heading(), rx, ry, pick_heading());
            end
            if (long_hold || $urandom_range(0, 3) == 0)
                gap = 0;
            else
                gap = $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);

        // Drain: every result in, then a pipeline's worth of quiet cycles
        // to catch anything the core sends without a request behind it.
        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        if (mismatch_count == 0 && pending_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== planar_relative_pose_core.f =====
src/prp_pkg.sv
src/prp_front.sv
src/prp_cordic_cell.sv
src/prp_back.sv
src/planar_relative_pose_core.sv
bench/planar_relative_pose_checker.sv
bench/tb_planar_relative_pose_core.sv
